// ===== hdl/gwm_pkg.sv =====
package gwm_pkg;

    // pattern capacity and derived widths
    localparam int MAX_PATTERN = 32;
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

    // special pattern bytes
    localparam logic [7:0] CHAR_STAR = 8'h2A;
    localparam logic [7:0] CHAR_ANY  = 8'h3F;

    typedef enum logic [1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_APPEND  = 2'd1,
        MODE_SUBJECT = 2'd2,
        MODE_END     = 2'd3
    } gwm_mode_t;

    typedef struct packed {
        gwm_mode_t  mode;
        logic [7:0] char_value;
    } gwm_item_t;

    typedef struct packed {
        logic matched;
        logic pattern_overflow;
    } gwm_result_t;

    // control broadcast to every cell
    typedef struct packed {
        logic       rearm;
        logic       advance;
        logic       write;
        logic [7:0] ch;
    } gwm_ctl_t;

endpackage

// ===== hdl/gwm_cell.sv =====
module gwm_cell (
    input  logic            clk,
    input  logic            rst_n,
    input  gwm_pkg::gwm_ctl_t ctl,
    input  logic            wr_sel,
    input  logic            active,
    input  logic            rearm_bit,
    input  logic            left_bit,
    input  logic            left_lit,
    output logic            match_bit,
    output logic            lit
);
    import gwm_pkg::*;

    logic [7:0] pat_reg;
    logic       match_reg;
    logic       match_next;
    logic       is_star;
    logic       char_hit;

    // decode of the stored pattern byte
    assign is_star  = (pat_reg == CHAR_STAR);
    assign char_hit = (pat_reg == CHAR_ANY) || (pat_reg == ctl.ch);

    // literal step, handed to the right neighbor for a star there
    assign lit = active && !is_star && left_bit && char_hit;

    // prefix bit update
    always_comb
    begin
        match_next = match_reg;
        if (ctl.rearm)
        begin
            match_next = rearm_bit;
        end
        else if (ctl.advance)
        begin
            if (!active)
            begin
                match_next = 1'b0;
            end
            else if (is_star)
            begin
                match_next = match_reg || left_lit;
            end
            else
            begin
                match_next = left_bit && char_hit;
            end
        end
    end

    // pattern byte, no reset
    always_ff @(posedge clk)
    begin
        if (ctl.write && wr_sel)
        begin
            pat_reg <= ctl.ch;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign match_bit = match_reg;

endmodule

// ===== hdl/glob_wildcard_matcher.sv =====
// one item accepted per cycle while the result register is free or draining
// mode 3 result appears in the output register in the cycle after its transfer
// each subject byte updates all pattern cells together
// reset: empty pattern, no overflow, prefix vector holds only the empty prefix
// pattern bytes themselves are not reset and are rewritten after each clear
module glob_wildcard_matcher (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  gwm_pkg::gwm_item_t   item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output gwm_pkg::gwm_result_t result
);
    import gwm_pkg::*;

    logic                   accept;
    logic                   is_star_in;
    logic                   fold;
    logic                   store_ok;
    logic                   drop;
    gwm_ctl_t               ctl;

    logic [LEN_W-1:0]       len_reg, len_next;
    logic                   ovf_reg, ovf_next;
    logic                   last_star_reg, last_star_next;
    logic                   lead_star_reg, lead_star_next;
    logic                   vec0_reg, vec0_next;
    logic                   result_valid_reg, result_valid_next;
    gwm_result_t            result_reg, result_next;

    logic [MAX_PATTERN:0]   vec_all;
    logic [MAX_PATTERN:0]   lit_w;

    // input transfer when the result slot is free or being taken
    assign item_stall = result_valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;
    assign is_star_in = (item.char_value == CHAR_STAR);

    // pattern append decisions
    assign fold     = !ovf_reg && is_star_in && last_star_reg;
    assign store_ok = !ovf_reg && !fold && (len_reg < LEN_W'(MAX_PATTERN));
    assign drop     = !fold && !store_ok;

    // cell control broadcast
    always_comb
    begin
        ctl.rearm   = accept && (item.mode != MODE_SUBJECT);
        ctl.advance = accept && (item.mode == MODE_SUBJECT);
        ctl.write   = accept && (item.mode == MODE_APPEND) && store_ok;
        ctl.ch      = item.char_value;
    end

    // pattern bookkeeping and empty-prefix bit
    always_comb
    begin
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        last_star_next = last_star_reg;
        lead_star_next = lead_star_reg;
        vec0_next      = vec0_reg;
        if (accept)
        begin
            unique case (item.mode)
                MODE_CLEAR:
                begin
                    len_next       = '0;
                    ovf_next       = 1'b0;
                    last_star_next = 1'b0;
                    lead_star_next = 1'b0;
                    vec0_next      = 1'b1;
                end
                MODE_APPEND:
                begin
                    if (store_ok)
                    begin
                        len_next       = len_reg + LEN_W'(1);
                        last_star_next = is_star_in;
                        if (len_reg == '0)
                        begin
                            lead_star_next = is_star_in;
                        end
                    end
                    else if (drop)
                    begin
                        ovf_next = 1'b1;
                    end
                    vec0_next = 1'b1;
                end
                MODE_SUBJECT:
                begin
                    vec0_next = 1'b0;
                end
                MODE_END:
                begin
                    vec0_next = 1'b1;
                end
                default:
                begin
                    vec0_next = vec0_reg;
                end
            endcase
        end
    end

    // row of pattern cells
    assign vec_all[0] = vec0_reg;
    assign lit_w[0]   = 1'b0;

    for (genvar k = 1; k <= MAX_PATTERN; k++)
    begin : g_cell
        gwm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .wr_sel    (len_reg == LEN_W'(k - 1)),
            .active    (len_reg >= LEN_W'(k)),
            .rearm_bit ((k == 1) ? lead_star_next : 1'b0),
            .left_bit  (vec_all[k-1]),
            .left_lit  (lit_w[k-1]),
            .match_bit (vec_all[k]),
            .lit       (lit_w[k])
        );
    end

    // output register
    always_comb
    begin
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        if (accept && (item.mode == MODE_END))
        begin
            result_valid_next       = 1'b1;
            result_next.matched          = vec_all[len_reg];
            result_next.pattern_overflow = ovf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg          <= '0;
            ovf_reg          <= 1'b0;
            last_star_reg    <= 1'b0;
            lead_star_reg    <= 1'b0;
            vec0_reg         <= 1'b1;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg          <= len_next;
            ovf_reg          <= ovf_next;
            last_star_reg    <= last_star_next;
            lead_star_reg    <= lead_star_next;
            vec0_reg         <= vec0_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // checks
    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(MAX_PATTERN))
        else $error("pattern length beyond capacity");

    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (len_reg == LEN_W'(MAX_PATTERN)))
        else $error("overflow flagged before pattern full");

    a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.mode == MODE_END)) |=> result_valid_reg)
        else $error("end of subject gave no result");

    a_rearm_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.mode != MODE_SUBJECT)) |=> vec0_reg)
        else $error("empty prefix not re-armed");

    a_lead_star: assert property (@(posedge clk) disable iff (!rst_n)
        lead_star_reg |-> (len_reg != '0))
        else $error("leading star flag with empty pattern");

endmodule

// ===== tb/sv/glob_wildcard_matcher_test.sv =====
module glob_wildcard_matcher_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gwm_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int PHASE_ITEMS    = 425;
    localparam int REPORT_MAX     = 10;
    localparam logic [7:0] LETTER_A = 8'h61;

    // one row of the directed table: item, repeat count, optional hand-typed verdict
    typedef struct packed {
        gwm_item_t   it;
        logic [7:0]  reps;
        logic        typed;
        gwm_result_t want;
    } dir_row_t;

    localparam int DIR_N = 30;
    localparam dir_row_t DIR_ROWS [DIR_N] = '{
        // empty pattern against empty subject
        '{'{MODE_END,     8'h00},     8'd1,  1'b1, '{1'b1, 1'b0}},
        // empty pattern against one byte
        '{'{MODE_SUBJECT, 8'h00},     8'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{MODE_END,     8'hFF},     8'd1,  1'b1, '{1'b0, 1'b0}},
        // repeated star is folded, star-only pattern takes empty and non-empty subjects
        '{'{MODE_APPEND,  CHAR_STAR}, 8'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{MODE_APPEND,  CHAR_STAR}, 8'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{MODE_END,     8'h00},     8'd1,  1'b1, '{1'b1, 1'b0}},
        '{'{MODE_SUBJECT, 8'hFF},     8'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{MODE_END,     8'h00},     8'd1,  1'b1, '{1'b1, 1'b0}},
        // star then any-byte: empty subject fails, one byte passes
        '{'{MODE_APPEND,  CHAR_ANY},  8'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{MODE_END,     8'h00},     8'd1,  1'b1, '{1'b0, 1'b0}},
        '{'{MODE_SUBJECT, 8'h78},     8'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{MODE_END,     8'h00},     8'd1,  1'b0, '{1'b0, 1'b0}},
        // literal extremes 00 and ff plus any-byte
        '{'{MODE_CLEAR,   8'hFF},     8'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{MODE_APPEND,  8'h00},     8'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{MODE_APPEND,  8'hFF},     8'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{MODE_APPEND,  CHAR_ANY},  8'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{MODE_SUBJECT, 8'h00},     8'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{MODE_SUBJECT, 8'hFF},     8'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{MODE_SUBJECT, 8'h55},     8'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{MODE_END,     8'h00},     8'd1,  1'b0, '{1'b0, 1'b0}},
        // overflowed pattern: only the stored prefix counts
        '{'{MODE_CLEAR,   8'h00},     8'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{MODE_APPEND,  LETTER_A},  8'd33, 1'b0, '{1'b0, 1'b0}},
        '{'{MODE_APPEND,  CHAR_STAR}, 8'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{MODE_SUBJECT, LETTER_A},  8'd32, 1'b0, '{1'b0, 1'b0}},
        '{'{MODE_END,     8'h00},     8'd1,  1'b1, '{1'b1, 1'b1}},
        '{'{MODE_END,     8'hFF},     8'd1,  1'b1, '{1'b0, 1'b1}},
        // clear drops the overflow flag
        '{'{MODE_CLEAR,   CHAR_STAR}, 8'd1,  1'b0, '{1'b0, 1'b0}},
        '{'{MODE_END,     8'h00},     8'd1,  1'b1, '{1'b1, 1'b0}},
        // long run of stars folds to one, never overflows
        '{'{MODE_APPEND,  CHAR_STAR}, 8'd40, 1'b0, '{1'b0, 1'b0}},
        '{'{MODE_END,     8'h00},     8'd1,  1'b1, '{1'b1, 1'b0}}
    };

    logic        clk;
    logic        rst_n;
    logic        item_valid;
    logic        item_stall;
    gwm_item_t   item;
    logic        result_valid;
    logic        result_stall = 1'b0;
    gwm_result_t result;

    // glob predictor state
    logic [7:0]           pat_bytes [MAX_PATTERN];
    int                   pat_len;
    logic [MAX_PATTERN:0] prefix_hits;
    logic                 pat_dropped;

    gwm_result_t verdicts_due [$];
    gwm_result_t due_verdict;
    logic [7:0]  pat_q [$];
    logic [7:0]  subj_q [$];
    int          idle_pct;
    int          stall_pct;
    int          items_sent;
    int          mismatches;
    int          cycle_count = 0;

    glob_wildcard_matcher dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // re-arm: empty prefix plus every prefix reached through leading stars
    function automatic void rearm_prefix();
        prefix_hits    = '0;
        prefix_hits[0] = 1'b1;
        for (int k = 1; k <= pat_len; k++)
        begin
            prefix_hits[k] = prefix_hits[k-1] && (pat_bytes[k-1] == CHAR_STAR);
        end
    endfunction

    // apply one item to the glob predictor, returns 1 when it yields a verdict
    function automatic bit predict_verdict(input gwm_item_t it, output gwm_result_t verdict);
        logic [MAX_PATTERN:0] nxt;
        logic [7:0]           p;
        bit                   fold;
        verdict = '0;
        case (it.mode)
            MODE_CLEAR:
            begin
                pat_len     = 0;
                pat_dropped = 1'b0;
                rearm_prefix();
                return 1'b0;
            end
            MODE_APPEND:
            begin
                fold = !pat_dropped && it.char_value == CHAR_STAR && pat_len > 0 &&
                       pat_bytes[pat_len-1] == CHAR_STAR;
                if (!fold)
                begin
                    if (!pat_dropped && pat_len < MAX_PATTERN)
                    begin
                        pat_bytes[pat_len] = it.char_value;
                        pat_len++;
                    end
                    else
                    begin
                        pat_dropped = 1'b1;
                    end
                end
                rearm_prefix();
                return 1'b0;
            end
            MODE_SUBJECT:
            begin
                nxt = '0;
                for (int k = 1; k <= pat_len; k++)
                begin
                    p = pat_bytes[k-1];
                    if (p == CHAR_STAR)
                        nxt[k] = prefix_hits[k] || nxt[k-1];
                    else
                        nxt[k] = prefix_hits[k-1] && (p == CHAR_ANY || p == it.char_value);
                end
                prefix_hits = nxt;
                return 1'b0;
            end
            default:
            begin
                verdict.matched          = prefix_hits[pat_len];
                verdict.pattern_overflow = pat_dropped;
                rearm_prefix();
                return 1'b1;
            end
        endcase
    endfunction

    // one input transfer, with random idle cycles ahead of it
    task automatic send_item(input gwm_mode_t m, input logic [7:0] c);
        gwm_item_t   it;
        gwm_result_t v;
        it.mode       = m;
        it.char_value = c;
        while ($urandom_range(99) < idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
        if (predict_verdict(it, v))
            verdicts_due = {verdicts_due, v};
    endtask

    function automatic logic [7:0] pick_letter();
        return LETTER_A + 8'($urandom_range(2));
    endfunction

    function automatic logic [7:0] pick_pattern_byte();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return CHAR_STAR;
        else if (r < 45)
            return CHAR_ANY;
        else if (r < 90)
            return pick_letter();
        else
            return 8'($urandom_range(255));
    endfunction

    // subject mostly built to fit the pattern, sometimes spoiled or random
    task automatic build_subject();
        int n;
        subj_q.delete();
        if ($urandom_range(99) < 65)
        begin
            foreach (pat_q[i])
            begin
                if (i < MAX_PATTERN)
                begin
                    if (pat_q[i] == CHAR_STAR)
                        repeat ($urandom_range(2)) subj_q = {subj_q, pick_letter()};
                    else if (pat_q[i] == CHAR_ANY)
                        subj_q = {subj_q, 8'($urandom_range(255))};
                    else
                        subj_q = {subj_q, pat_q[i]};
                end
            end
            if ($urandom_range(99) < 30)
            begin
                if (subj_q.size() > 0)
                    subj_q[$urandom_range(subj_q.size() - 1)] = pick_letter();
                else
                    subj_q = {subj_q, pick_letter()};
            end
        end
        else
        begin
            n = $urandom_range(5);
            repeat (n)
                subj_q = {subj_q, (($urandom_range(1) == 0) ? pick_letter()
                                                             : 8'($urandom_range(255)))};
        end
    endtask

    // random traffic: mostly pattern load then a few subjects, some noise
    task automatic random_phase(input int n_items);
        int goal;
        int r;
        int plen;
        logic [7:0] b;
        goal = items_sent + n_items;
        while (items_sent < goal)
        begin
            r = $urandom_range(99);
            if (r < 8)
            begin
                send_item(gwm_mode_t'($urandom_range(3)), 8'($urandom_range(255)));
            end
            else
            begin
                if (r >= 20)
                begin
                    pat_q.delete();
                    send_item(MODE_CLEAR, 8'($urandom_range(255)));
                end
                plen = ($urandom_range(99) < 88) ? $urandom_range(8) : $urandom_range(40, 25);
                repeat (plen)
                begin
                    b = pick_pattern_byte();
                    pat_q = {pat_q, b};
                    send_item(MODE_APPEND, b);
                end
                repeat ($urandom_range(4, 1))
                begin
                    build_subject();
                    foreach (subj_q[i])
                        send_item(MODE_SUBJECT, subj_q[i]);
                    send_item(MODE_END, 8'($urandom_range(255)));
                end
            end
        end
    endtask

    // sender holds off until every verdict is back
    task automatic drain_verdicts();
        item_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
    endtask

    // result side: check each transfer, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (verdicts_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result transfer: matched=%0b overflow=%0b",
                             result.matched, result.pattern_overflow);
            end
            else
            begin
                due_verdict = verdicts_due.pop_front();
                if (result.matched !== due_verdict.matched ||
                    result.pattern_overflow !== due_verdict.pattern_overflow)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display({"verdict mismatch: expected matched=%0b overflow=%0b,",
                                  " got matched=%0b overflow=%0b"},
                                 due_verdict.matched, due_verdict.pattern_overflow,
                                 result.matched, result.pattern_overflow);
                end
            end
        end
        result_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        rst_n        <= 1'b0;
        item_valid   <= 1'b0;
        item         <= '0;
        idle_pct     = 0;
        stall_pct    = 0;
        items_sent   = 0;
        mismatches   = 0;
        pat_len      = 0;
        pat_dropped  = 1'b0;
        rearm_prefix();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (DIR_ROWS[i])
        begin
            repeat (DIR_ROWS[i].reps)
                send_item(DIR_ROWS[i].it.mode, DIR_ROWS[i].it.char_value);
            if (DIR_ROWS[i].typed)
            begin
                verdicts_due[verdicts_due.size() - 1] = DIR_ROWS[i].want;
            end
        end
        drain_verdicts();
        repeat (3) @(posedge clk);

        // random phases: no idling, sender idle, receiver stalling, both
        random_phase(PHASE_ITEMS);
        idle_pct  = 84;
        stall_pct = 0;
        random_phase(PHASE_ITEMS);
        drain_verdicts();
        repeat (3) @(posedge clk);
        idle_pct  = 0;
        stall_pct = 84;
        random_phase(PHASE_ITEMS);
        idle_pct  = 29;
        stall_pct = 29;
        random_phase(PHASE_ITEMS);

        // wind down
        drain_verdicts();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
